[hw/rtl/assert_macros.svh]
// Assertion helpers shared by the queue and the top-level RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hw/rtl/pwc_pkg.sv]
`default_nettype none
package pwc_pkg;

  // Upper bound on walls; vectors that travel with an item use this width.
  localparam int WALL_LIM = 8;
  // Quotient bits kept by the divider; anything larger saturates anyway.
  localparam int QBITS = 17;
  localparam int DIV_LAT = QBITS + 2;
  localparam int MAGW = 49;
  localparam int CFG_W = 64;
  localparam int REG_COUNT = 0;

  typedef logic signed [15:0] q16_t;

  typedef struct packed {
    logic signed [15:0] nx;
    logic signed [15:0] ny;
    logic signed [15:0] px;
    logic signed [15:0] py;
  } wall_t;

  typedef struct packed {
    logic signed [15:0] rx;
    logic signed [15:0] ry;
    logic signed [15:0] wx;
    logic signed [15:0] wy;
    logic [WALL_LIM-1:0] hit;
    logic [WALL_LIM-1:0] pend;
    logic [WALL_LIM-1:0] refl;
    logic                last;
  } item_t;

  // Applies x - t, where t = +/-q or an out-of-range quotient, with saturation.
  function automatic q16_t apply_corr(input q16_t x, input logic neg, input logic ovf,
                                      input logic [QBITS-1:0] q);
    logic signed [18:0] t;
    logic signed [18:0] diff;
    q16_t res;
    t = neg ? -$signed({2'b00, q}) : $signed({2'b00, q});
    diff = 19'(x) - t;
    if (ovf) begin
      res = neg ? 16'sh7fff : -16'sh8000;
    end else if (diff > 19'sd32767) begin
      res = 16'sh7fff;
    end else if (diff < -19'sd32768) begin
      res = -16'sh8000;
    end else begin
      res = diff[15:0];
    end
    return res;
  endfunction

endpackage
`default_nettype wire

[hw/rtl/pwc_fifo.sv]
`default_nettype none
module pwc_fifo #(
  parameter int W = 8,
  parameter int DEPTH = 4
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         push_i,
  input  wire logic [W-1:0] data_i,
  input  wire logic         pop_i,
  output logic              full_o,
  output logic              empty_o,
  output logic [W-1:0]      data_o
);
  `include "assert_macros.svh"

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic [W-1:0]  mem_r [DEPTH];
  logic [PW-1:0] wr_ptr_r;
  logic [PW-1:0] rd_ptr_r;
  logic [CW-1:0] count_r;

  assign full_o  = (count_r == CW'(DEPTH));
  assign empty_o = (count_r == '0);
  assign data_o  = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push_i) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (pop_i)  rd_ptr_r <= rd_ptr_r + 1'b1;
      if (push_i && !pop_i) begin
        count_r <= count_r + 1'b1;
      end else if (pop_i && !push_i) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push_i) mem_r[wr_ptr_r] <= data_i;
  end

  `ASSERT_NOW(a_push_room, push_i, !full_o, "push into a full queue")
  `ASSERT_NOW(a_pop_data, pop_i, !empty_o, "pop from an empty queue")
  `ASSERT_NOW(a_ptr_track, count_r == '0, wr_ptr_r == rd_ptr_r, "pointers out of step")

endmodule
`default_nettype wire

[hw/rtl/pwc_front.sv]
`default_nettype none
module pwc_front #(
  parameter int MAX_WALLS = 4
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                adv_i,
  input  wire logic                                valid_i,
  input  wire pwc_pkg::item_t                      item_i,
  input  wire pwc_pkg::wall_t [MAX_WALLS-1:0]      walls_i,
  input  wire logic [MAX_WALLS-1:0][31:0]          nn_i,
  input  wire logic [MAX_WALLS-1:0][32:0]          np_i,
  input  wire logic [2:0]                          count_i,
  output logic                                     valid_o,
  output pwc_pkg::item_t                           item_o
);

  logic v1_r;
  logic v2_r;
  pwc_pkg::item_t it1_r;
  pwc_pkg::item_t it2_r;
  logic signed [31:0] pqx_r [MAX_WALLS];
  logic signed [31:0] pqy_r [MAX_WALLS];
  logic signed [31:0] pvx_r [MAX_WALLS];
  logic signed [31:0] pvy_r [MAX_WALLS];
  logic signed [32:0] nq_c;
  logic signed [32:0] nv_c;
  logic [pwc_pkg::WALL_LIM-1:0] hit_c;
  logic [pwc_pkg::WALL_LIM-1:0] move_c;
  pwc_pkg::item_t cls_c;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else if (adv_i) begin
      v1_r <= valid_i;
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv_i) begin
      it1_r <= item_i;
      for (int k = 0; k < MAX_WALLS; k++) begin
        pqx_r[k] <= walls_i[k].nx * item_i.rx;
        pqy_r[k] <= walls_i[k].ny * item_i.ry;
        pvx_r[k] <= walls_i[k].nx * item_i.wx;
        pvy_r[k] <= walls_i[k].ny * item_i.wy;
      end
    end
  end

  // A wall counts only when it is in use, has a nonzero normal and the
  // arriving position lies behind it.
  always_comb begin
    hit_c  = '0;
    move_c = '0;
    nq_c   = '0;
    nv_c   = '0;
    for (int k = 0; k < MAX_WALLS; k++) begin
      nq_c = 33'(pqx_r[k]) + 33'(pqy_r[k]);
      nv_c = 33'(pvx_r[k]) + 33'(pvy_r[k]);
      hit_c[k]  = (k < int'(count_i)) && (nn_i[k] != '0) && (nq_c < $signed(np_i[k]));
      move_c[k] = nv_c[32];
    end
  end

  always_comb begin
    cls_c      = it1_r;
    cls_c.hit  = hit_c;
    cls_c.pend = hit_c;
    cls_c.refl = hit_c & move_c;
  end

  always_ff @(posedge clk) begin
    if (adv_i) it2_r <= cls_c;
  end

  assign valid_o = v2_r;
  assign item_o  = it2_r;

endmodule
`default_nettype wire

[hw/rtl/pwc_div.sv]
`default_nettype none
module pwc_div (
  input  wire logic                      clk,
  input  wire logic                      adv_i,
  input  wire logic signed [49:0]        num_i,
  input  wire logic [31:0]               den_i,
  output logic [pwc_pkg::QBITS-1:0]      q_o,
  output logic                           neg_o,
  output logic                           ovf_o
);
  localparam int QB = pwc_pkg::QBITS;
  localparam int MW = pwc_pkg::MAGW;

  logic [MW-1:0] mag_r;
  logic          neg0_r;
  logic [MW-1:0] rem_r [QB+1];
  logic [QB-1:0] q_r   [QB+1];
  logic          neg_r [QB+1];
  logic          ovf_r [QB+1];
  logic signed [49:0] neg_num_c;

  assign neg_num_c = -num_i;

  always_ff @(posedge clk) begin
    if (adv_i) begin
      mag_r    <= num_i[49] ? MW'(neg_num_c) : MW'(num_i);
      neg0_r   <= num_i[49];
      rem_r[0] <= mag_r;
      q_r[0]   <= '0;
      neg_r[0] <= neg0_r;
      ovf_r[0] <= (mag_r >= (MW'(den_i) << QB));
    end
  end

  // One restoring step per stage, most significant quotient bit first.
  for (genvar j = 0; j < QB; j++) begin : g_bit
    logic [MW:0] trial_c;
    assign trial_c = {1'b0, rem_r[j]} - ((MW + 1)'(den_i) << (QB - 1 - j));
    always_ff @(posedge clk) begin
      if (adv_i) begin
        rem_r[j+1] <= trial_c[MW] ? rem_r[j] : trial_c[MW-1:0];
        q_r[j+1]   <= q_r[j] | (trial_c[MW] ? '0 : (QB'(1) << (QB - 1 - j)));
        neg_r[j+1] <= neg_r[j];
        ovf_r[j+1] <= ovf_r[j];
      end
    end
  end

  assign q_o   = q_r[QB];
  assign neg_o = neg_r[QB];
  assign ovf_o = ovf_r[QB];

endmodule
`default_nettype wire

[hw/rtl/pwc_wall.sv]
`default_nettype none
module pwc_wall (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            adv_i,
  input  wire logic            valid_i,
  input  wire pwc_pkg::item_t  item_i,
  input  wire pwc_pkg::wall_t  wall_i,
  input  wire logic [31:0]     nn_i,
  output logic                 valid_o,
  output pwc_pkg::item_t       item_o
);
  localparam int DL = pwc_pkg::DIV_LAT;
  localparam int QB = pwc_pkg::QBITS;

  logic v1_r, v2_r, v3_r, vo_r;
  pwc_pkg::item_t it1_r, it2_r, it3_r, ito_r;
  logic signed [32:0] mx_r, my_r;
  logic signed [31:0] vx_r, vy_r;
  logic signed [33:0] d_r, wn_r;
  logic signed [49:0] p_r [4];
  logic               vd_r  [DL];
  pwc_pkg::item_t     itd_r [DL];

  logic signed [16:0] ex_c, ey_c;
  logic signed [33:0] wsum_c;
  logic signed [49:0] p_c [4];
  logic [QB-1:0] q_c [4];
  logic          neg_c [4];
  logic          ovf_c [4];
  pwc_pkg::item_t et_c;

  assign ex_c   = item_i.rx - wall_i.px;
  assign ey_c   = item_i.ry - wall_i.py;
  assign wsum_c = 34'(vx_r) + 34'(vy_r);

  always_comb begin
    p_c[0] = d_r * wall_i.nx;
    p_c[1] = d_r * wall_i.ny;
    p_c[2] = wn_r * wall_i.nx;
    p_c[3] = wn_r * wall_i.ny;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      vo_r <= 1'b0;
      for (int s = 0; s < DL; s++) vd_r[s] <= 1'b0;
    end else if (adv_i) begin
      v1_r <= valid_i;
      v2_r <= v1_r;
      v3_r <= v2_r;
      vd_r[0] <= v3_r;
      for (int s = 1; s < DL; s++) vd_r[s] <= vd_r[s-1];
      vo_r <= vd_r[DL-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv_i) begin
      it1_r <= item_i;
      mx_r  <= ex_c * wall_i.nx;
      my_r  <= ey_c * wall_i.ny;
      vx_r  <= item_i.wx * wall_i.nx;
      vy_r  <= item_i.wy * wall_i.ny;
      it2_r <= it1_r;
      d_r   <= 34'(mx_r) + 34'(my_r);
      wn_r  <= wsum_c <<< 1;
      it3_r <= it2_r;
      for (int c = 0; c < 4; c++) p_r[c] <= p_c[c];
      itd_r[0] <= it3_r;
      for (int s = 1; s < DL; s++) itd_r[s] <= itd_r[s-1];
    end
  end

  for (genvar c = 0; c < 4; c++) begin : g_div
    pwc_div u_div (
      .clk   (clk),
      .adv_i (adv_i),
      .num_i (p_r[c]),
      .den_i (nn_i),
      .q_o   (q_c[c]),
      .neg_o (neg_c[c]),
      .ovf_o (ovf_c[c])
    );
  end

  // The position is projected on a hit; the velocity is reflected only when
  // the particle was also moving outward.
  always_comb begin
    et_c = itd_r[DL-1];
    if (itd_r[DL-1].pend[0]) begin
      et_c.rx = pwc_pkg::apply_corr(itd_r[DL-1].rx, neg_c[0], ovf_c[0], q_c[0]);
      et_c.ry = pwc_pkg::apply_corr(itd_r[DL-1].ry, neg_c[1], ovf_c[1], q_c[1]);
    end
    if (itd_r[DL-1].refl[0]) begin
      et_c.wx = pwc_pkg::apply_corr(itd_r[DL-1].wx, neg_c[2], ovf_c[2], q_c[2]);
      et_c.wy = pwc_pkg::apply_corr(itd_r[DL-1].wy, neg_c[3], ovf_c[3], q_c[3]);
    end
    et_c.pend = itd_r[DL-1].pend >> 1;
    et_c.refl = itd_r[DL-1].refl >> 1;
  end

  always_ff @(posedge clk) begin
    if (adv_i) ito_r <= et_c;
  end

  assign valid_o = vo_r;
  assign item_o  = ito_r;

endmodule
`default_nettype wire

[hw/rtl/particle_wall_collision_resolve.sv]
// Particle against planar walls, one particle per request.
// Input queue side: drive in_* and raise in_push; a request is taken at a
// clock edge where in_push is high and in_full is low.
// Result queue side: while out_empty is low the oldest result sits on out_*;
// it is taken at an edge where out_pop is high.
// Configuration: cfg_we with cfg_index 0 writes the wall count, index 1 + k
// writes wall k (normal x, normal y, point x, point y, high to low). Write only
// while no particle is in flight.
// Each wall stage is a fixed pipeline of three multiply-add stages, a 19-stage
// restoring divider and a saturating update, so every particle walks through
// all wall stages.
// Throughput: one particle per cycle while the result side pops.
// Reset: synchronous, active low; clears walls, count and all queues.
// When the result side stalls, the wall pipeline holds, the middle queue fills
// and in_full rises; nothing is dropped.
`default_nettype none
module particle_wall_collision_resolve #(
  parameter int MAX_WALLS = 4
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  input  wire logic                                  cfg_we,
  input  wire logic [$clog2(MAX_WALLS+1)-1:0]        cfg_index,
  input  wire logic [pwc_pkg::CFG_W-1:0]             cfg_data,
  input  wire logic                                  in_push,
  output logic                                       in_full,
  input  wire logic signed [15:0]                    in_pos_x,
  input  wire logic signed [15:0]                    in_pos_y,
  input  wire logic signed [15:0]                    in_vel_x,
  input  wire logic signed [15:0]                    in_vel_y,
  input  wire logic                                  in_final_particle,
  output logic                                       out_empty,
  input  wire logic                                  out_pop,
  output logic signed [15:0]                         out_new_pos_x,
  output logic signed [15:0]                         out_new_pos_y,
  output logic signed [15:0]                         out_new_vel_x,
  output logic signed [15:0]                         out_new_vel_y,
  output logic [MAX_WALLS-1:0]                       out_hit_mask,
  output logic                                       out_final_out
);
  `include "assert_macros.svh"

  localparam int IDXW = $clog2(MAX_WALLS + 1);
  localparam int IW = $bits(pwc_pkg::item_t);

  logic [2:0] count_r;
  pwc_pkg::wall_t [MAX_WALLS-1:0] wall_r;
  logic [MAX_WALLS-1:0][31:0] nn_r;
  logic [MAX_WALLS-1:0][32:0] np_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      wall_r  <= '0;
    end else if (cfg_we) begin
      if (cfg_index == IDXW'(pwc_pkg::REG_COUNT)) count_r <= cfg_data[2:0];
      for (int k = 0; k < MAX_WALLS; k++) begin
        if (cfg_index == IDXW'(k + 1)) wall_r[k] <= cfg_data;
      end
    end
  end

  // Per-wall constants: |n|^2 and n.p, refreshed every cycle from the walls.
  always_ff @(posedge clk) begin
    for (int k = 0; k < MAX_WALLS; k++) begin
      nn_r[k] <= 32'(wall_r[k].nx * wall_r[k].nx) + 32'(wall_r[k].ny * wall_r[k].ny);
      np_r[k] <= 33'(wall_r[k].nx * wall_r[k].px) + 33'(wall_r[k].ny * wall_r[k].py);
    end
  end

  pwc_pkg::item_t in_item;
  pwc_pkg::item_t fr_item, mq_item, oq_item;
  logic fr_valid, mq_full, mq_empty, oq_full;
  logic adv_f, adv_b, mq_pop;
  logic           cv [MAX_WALLS+1];
  pwc_pkg::item_t ci [MAX_WALLS+1];

  always_comb begin
    in_item      = '0;
    in_item.rx   = in_pos_x;
    in_item.ry   = in_pos_y;
    in_item.wx   = in_vel_x;
    in_item.wy   = in_vel_y;
    in_item.last = in_final_particle;
  end

  assign adv_f   = !mq_full;
  assign in_full = !adv_f;
  assign adv_b   = !oq_full;
  assign mq_pop  = adv_b && !mq_empty;

  pwc_front #(.MAX_WALLS(MAX_WALLS)) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .adv_i   (adv_f),
    .valid_i (in_push && !in_full),
    .item_i  (in_item),
    .walls_i (wall_r),
    .nn_i    (nn_r),
    .np_i    (np_r),
    .count_i (count_r),
    .valid_o (fr_valid),
    .item_o  (fr_item)
  );

  pwc_fifo #(.W(IW), .DEPTH(4)) u_midq (
    .clk     (clk),
    .rst_n   (rst_n),
    .push_i  (fr_valid && adv_f),
    .data_i  (fr_item),
    .pop_i   (mq_pop),
    .full_o  (mq_full),
    .empty_o (mq_empty),
    .data_o  (mq_item)
  );

  assign cv[0] = mq_pop;
  assign ci[0] = mq_item;

  for (genvar k = 0; k < MAX_WALLS; k++) begin : g_wall
    pwc_wall u_wall (
      .clk     (clk),
      .rst_n   (rst_n),
      .adv_i   (adv_b),
      .valid_i (cv[k]),
      .item_i  (ci[k]),
      .wall_i  (wall_r[k]),
      .nn_i    (nn_r[k]),
      .valid_o (cv[k+1]),
      .item_o  (ci[k+1])
    );
  end

  pwc_fifo #(.W(IW), .DEPTH(2)) u_outq (
    .clk     (clk),
    .rst_n   (rst_n),
    .push_i  (cv[MAX_WALLS] && adv_b),
    .data_i  (ci[MAX_WALLS]),
    .pop_i   (out_pop && !out_empty),
    .full_o  (oq_full),
    .empty_o (out_empty),
    .data_o  (oq_item)
  );

  assign out_new_pos_x = oq_item.rx;
  assign out_new_pos_y = oq_item.ry;
  assign out_new_vel_x = oq_item.wx;
  assign out_new_vel_y = oq_item.wy;
  assign out_hit_mask  = oq_item.hit[MAX_WALLS-1:0];
  assign out_final_out = oq_item.last;

endmodule
`default_nettype wire

[dv/particle_wall_collision_resolve_tb.sv]
`default_nettype none
module particle_wall_collision_resolve_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NWALL = 4;
  localparam int IDX_W = $clog2(NWALL + 1);
  localparam int IDX_COUNT = 0;
  localparam int IDX_WALL0 = 1;
  localparam int LATENCY = 3 + 23 * NWALL;
  localparam int CYCLE_LIMIT = 400000;

  typedef struct packed {
    logic signed [15:0] px;
    logic signed [15:0] py;
    logic signed [15:0] vx;
    logic signed [15:0] vy;
    logic               last;
  } particle_t;

  typedef struct packed {
    logic signed [15:0] px;
    logic signed [15:0] py;
    logic signed [15:0] vx;
    logic signed [15:0] vy;
    logic [NWALL-1:0]   hit;
    logic               last;
  } resolved_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [IDX_W-1:0] cfg_index = '0;
  logic [pwc_pkg::CFG_W-1:0] cfg_data = '0;
  logic in_push = 1'b0;
  logic in_full;
  logic signed [15:0] in_pos_x = '0, in_pos_y = '0, in_vel_x = '0, in_vel_y = '0;
  logic in_final_particle = 1'b0;
  logic out_empty;
  logic out_pop = 1'b0;
  logic signed [15:0] out_new_pos_x, out_new_pos_y, out_new_vel_x, out_new_vel_y;
  logic [NWALL-1:0] out_hit_mask;
  logic out_final_out;

  particle_wall_collision_resolve #(.MAX_WALLS(NWALL)) u_top (.*);

  always #5 clk = ~clk;

  logic [2:0] wall_count_sh = '0;
  logic [63:0] wall_sh [NWALL];
  particle_t pending_particles[$];
  resolved_t expected_results[$];
  int errors = 0;
  int results_seen = 0;
  int hits_seen = 0;
  int cycles = 0;
  int hold_off = 0;

  function automatic logic signed [15:0] clamp16(longint v);
    if (v > 32767) return 16'sh7fff;
    if (v < -32768) return -16'sh8000;
    return v[15:0];
  endfunction

  function automatic resolved_t resolve_particle(particle_t p);
    resolved_t r;
    longint nx, ny, wpx, wpy, nn, d, wn;
    longint rx, ry, wx, wy;
    int cnt;
    rx = p.px; ry = p.py; wx = p.vx; wy = p.vy;
    r.hit = '0;
    cnt = (wall_count_sh > NWALL) ? NWALL : wall_count_sh;
    for (int k = 0; k < cnt; k++) begin
      nx = $signed(wall_sh[k][63:48]);
      ny = $signed(wall_sh[k][47:32]);
      wpx = $signed(wall_sh[k][31:16]);
      wpy = $signed(wall_sh[k][15:0]);
      nn = nx * nx + ny * ny;
      if (nn == 0) continue;
      if (!(nx * p.px + ny * p.py < nx * wpx + ny * wpy)) continue;
      r.hit[k] = 1'b1;
      d = (rx - wpx) * nx + (ry - wpy) * ny;
      rx = clamp16(rx - (d * nx) / nn);
      ry = clamp16(ry - (d * ny) / nn);
      if (nx * p.vx + ny * p.vy < 0) begin
        wn = 2 * (nx * wx + ny * wy);
        wx = clamp16(wx - (wn * nx) / nn);
        wy = clamp16(wy - (wn * ny) / nn);
      end
    end
    r.px = rx[15:0]; r.py = ry[15:0]; r.vx = wx[15:0]; r.vy = wy[15:0];
    r.last = p.last;
    return r;
  endfunction

  // Driver: one request at a time, with a random gap before each.
  int send_gap = 0;
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_push && !in_full) begin
        expected_results.push_back(resolve_particle(pending_particles.pop_front()));
        send_gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 16);
        if ($urandom_range(0, 3) == 0) send_gap = 0;
      end
      if (!(in_push && in_full)) begin
        if (send_gap > 0) begin
          send_gap--;
          in_push <= 1'b0;
        end else if (pending_particles.size() > 0 &&
                     !(in_push && !in_full && pending_particles.size() == 0)) begin
          in_push <= 1'b1;
          {in_pos_x, in_pos_y, in_vel_x, in_vel_y, in_final_particle} <=
            pending_particles[0];
        end else begin
          in_push <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks popped results and draws the next stall.
  int pop_gap = 0;
  always @(posedge clk) begin
    resolved_t got, want;
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", cycles);
      $display("Test completed with failures");
      $finish;
    end
    if (rst_n) begin
      if (out_pop && !out_empty) begin
        got = {out_new_pos_x, out_new_pos_y, out_new_vel_x, out_new_vel_y,
               out_hit_mask, out_final_out};
        results_seen++;
        if (out_hit_mask != 0) hits_seen++;
        if (expected_results.size() == 0) begin
          errors++;
          if (errors <= 10) $display("Unexpected result %h", got);
        end else begin
          want = expected_results.pop_front();
          if (got !== want) begin
            errors++;
            if (errors <= 10)
              $display("Mismatch: pos %0d,%0d vel %0d,%0d hit %h last %b, expected %0d,%0d %0d,%0d %h %b",
                       got.px, got.py, got.vx, got.vy, got.hit, got.last,
                       want.px, want.py, want.vx, want.vy, want.hit, want.last);
          end
        end
        pop_gap = $urandom_range(0, 2) == 0 ? 0 : $urandom_range(0, 16);
      end
      if (hold_off > 0) begin
        hold_off--;
        out_pop <= 1'b0;
      end else if (pop_gap > 0) begin
        pop_gap--;
        out_pop <= 1'b0;
      end else begin
        out_pop <= 1'b1;
      end
    end
  end

  task automatic write_reg(int idx, logic [63:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx[IDX_W-1:0];
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == IDX_COUNT) wall_count_sh = val[2:0];
    else if (idx - IDX_WALL0 < NWALL) wall_sh[idx - IDX_WALL0] = val;
  endtask

  task automatic drain;
    while (pending_particles.size() > 0 || in_push || expected_results.size() > 0)
      @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
  endtask

  function automatic logic [15:0] pick16();
    case ($urandom_range(0, 5))
      0: return 16'h7fff;
      1: return 16'h8000;
      2: return 16'h0000;
      3: return 16'($signed($urandom_range(0, 2048)) - 1024);
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [63:0] random_wall();
    logic [15:0] nx, ny;
    case ($urandom_range(0, 4))
      0: begin nx = 16'h0100; ny = 16'h0000; end
      1: begin nx = 16'h0000; ny = 16'hff00; end
      2: begin nx = 16'($urandom_range(0, 512)) - 16'd256;
               ny = 16'($urandom_range(0, 512)) - 16'd256; end
      3: begin nx = 16'h0000; ny = 16'h0000; end
      default: begin nx = pick16(); ny = pick16(); end
    endcase
    return {nx, ny, pick16(), pick16()};
  endfunction

  task automatic push_particle(logic [15:0] a, logic [15:0] b, logic [15:0] c,
                               logic [15:0] d, logic e);
    particle_t p;
    p = {a, b, c, d, e};
    pending_particles.push_back(p);
  endtask

  initial begin
    for (int k = 0; k < NWALL; k++) wall_sh[k] = '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset state: no walls, the particle passes through.
    push_particle(16'h7fff, 16'h8000, 16'h8000, 16'h7fff, 1'b1);
    drain();

    // Directed: left wall at x=0, floor at y=0, a zero-normal wall, a tilted wall.
    write_reg(IDX_WALL0 + 0, {16'h0100, 16'h0000, 16'h0000, 16'h0000});
    write_reg(IDX_WALL0 + 1, {16'h0000, 16'h0100, 16'h0000, 16'h0000});
    write_reg(IDX_WALL0 + 2, 64'h0000_0000_1234_5678);
    write_reg(IDX_WALL0 + 3, {16'h8000, 16'h7fff, 16'h7fff, 16'h8000});
    write_reg(IDX_COUNT, 4);
    push_particle(16'hff00, 16'h0100, 16'hff00, 16'h0100, 1'b0); // hit, moving out
    push_particle(16'hff00, 16'h0100, 16'h0100, 16'h0100, 1'b0); // hit, moving in
    push_particle(16'h0100, 16'h0100, 16'h0100, 16'h0100, 1'b0); // no hit
    push_particle(16'h8000, 16'h8000, 16'h8000, 16'h8000, 1'b0); // corner, saturation
    push_particle(16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 1'b1);
    push_particle(16'h8000, 16'h7fff, 16'h7fff, 16'h8000, 1'b0);
    push_particle(16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b1);
    drain();
    // Counts above the wall limit act as the limit.
    write_reg(IDX_COUNT, 7);
    push_particle(16'hff00, 16'hff00, 16'h8000, 16'h8000, 1'b1);
    push_particle(16'h8001, 16'hffff, 16'h0001, 16'h7fff, 1'b0);
    drain();
    write_reg(IDX_COUNT, 0);
    push_particle(16'hff00, 16'hff00, 16'h8000, 16'h8000, 1'b1);
    drain();

    // Random phases with fresh walls; one phase holds off the receiver.
    for (int ph = 0; ph < 11; ph++) begin
      for (int k = 0; k < NWALL; k++) write_reg(IDX_WALL0 + k, random_wall());
      write_reg(IDX_COUNT, ph == 0 ? 4 : $urandom_range(0, 7));
      if (ph == 2) hold_off = 400;
      for (int i = 0; i < 50; i++)
        push_particle(pick16(), pick16(), pick16(), pick16(), 1'($urandom));
      drain();
    end

    $display("Checked %0d particles over 11 random wall settings, %0d with walls hit.",
             results_seen, hits_seen);
    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("%0d mismatches", errors);
      $display("Test completed with failures");
    end
    $finish;
  end
endmodule
`default_nettype wire
